### src/stm_pkg.sv
package stm_pkg;

	localparam int unsigned TIME_W     = 24;
	localparam int unsigned LIMIT_W    = 15;
	localparam int unsigned LOAD_W     = 16;
	localparam int unsigned COUNT_W    = 32;
	localparam int unsigned SCALE_W    = 14;
	localparam int unsigned MS_W       = 10;
	localparam int unsigned LIMIT_US_W = LIMIT_W + MS_W;
	localparam int unsigned DIVIDEND_W = TIME_W + SCALE_W;
	localparam int unsigned DIVISOR_W  = TIME_W;
	localparam int unsigned STEP_W     = $clog2(DIVIDEND_W);

	localparam logic [SCALE_W-1:0] LOAD_SCALE = SCALE_W'(10000);
	localparam logic [MS_W-1:0]    MS_TO_US   = MS_W'(1000);
	localparam logic [LOAD_W-1:0]  LOAD_MAX   = '1;

	typedef struct packed {
		logic [TIME_W-1:0] scan_time;
		logic [TIME_W-1:0] work_time;
		logic [TIME_W-1:0] cycle_time;
	} stm_in_t;

	typedef struct packed {
		logic [TIME_W-1:0]  scan_average;
		logic [TIME_W-1:0]  scan_peak;
		logic [TIME_W-1:0]  work_average;
		logic [TIME_W-1:0]  work_peak;
		logic [TIME_W-1:0]  cycle_average;
		logic [TIME_W-1:0]  cycle_peak;
		logic [LOAD_W-1:0]  load_hundredths;
		logic [COUNT_W-1:0] overrun_count;
	} stm_out_t;

	typedef struct packed {
		logic busy;
		logic done;
	} stm_div_status_t;

endpackage

### src/stm_divider.sv
module stm_divider
	import stm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic [DIVIDEND_W-1:0] quotient,
	output stm_div_status_t       status
);

	// The quotient shifts in from the right as the dividend shifts out on the left.
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dsr_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W+1:0]  diff;
	logic                  fits;

	always_comb begin
		trial = {rem_q, quo_q[DIVIDEND_W-1]};
		diff  = {1'b0, trial} - {2'b00, dsr_q};
		fits  = ~diff[DIVISOR_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			// The done pulse follows the last quotient bit.
			done_q <= !start && busy_q && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
			rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

### src/scan_timing_monitor.sv
// Flow: an accepted word passes ST_START, then ST_DIV, where the bit-serial load divider
// works (one quotient bit per cycle over 38 bits), then ST_FIN, where the result moves into
// the output register and out_valid rises once that register is free or emptying.
// A word with zero cycle time skips the divider: it goes from ST_START straight to ST_FIN.
// One word at a time; the input stalls until the result has moved into the output register,
// so a new word is not taken while the previous one is still in progress.
// Reset (arst_n, asynchronous, active low) clears all averages, peaks, load,
// overrun count and the scan limit; the first word after reset seeds the averages.
module scan_timing_monitor
	import stm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  stm_in_t            in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output stm_out_t           out_data,
	input  logic               cfg_we,
	input  logic [LIMIT_W-1:0] cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t state_q;

	// Running figures. They change only when a word is accepted or the division ends,
	// so the result can be assembled from them once the load is known.
	logic                  first_seen_q;
	logic [TIME_W-1:0]     avg_scan_q;
	logic [TIME_W-1:0]     avg_work_q;
	logic [TIME_W-1:0]     avg_cycle_q;
	logic [TIME_W-1:0]     max_scan_q;
	logic [TIME_W-1:0]     max_work_q;
	logic [TIME_W-1:0]     max_cycle_q;
	logic [LOAD_W-1:0]     load_q;
	logic [COUNT_W-1:0]    overruns_q;

	// The limit is kept already scaled to microseconds; zero still means disabled.
	logic [LIMIT_US_W-1:0] limit_us_q;

	// Operands for the load divider, captured at acceptance.
	logic [DIVIDEND_W-1:0] product_q;
	logic [DIVISOR_W-1:0]  cycle_q;

	logic                  out_valid_q;
	stm_out_t              out_data_q;

	logic                  accept;
	logic                  div_start;
	logic [DIVIDEND_W-1:0] quotient;
	stm_div_status_t       div_status;
	logic                  over_limit;
	logic [LOAD_W-1:0]     load_sat;
	logic                  hand_over;

	// Moves one eighth of the distance toward the sample, truncated toward prev.
	function automatic logic [TIME_W-1:0] ema_eighth(input logic [TIME_W-1:0] prev,
			input logic [TIME_W-1:0] sample);
		logic [TIME_W-1:0] result;
		if (sample >= prev) begin
			result = prev + ((sample - prev) >> 3);
		end else begin
			result = prev - ((prev - sample) >> 3);
		end
		return result;
	endfunction

	function automatic logic [TIME_W-1:0] peak_of(input logic [TIME_W-1:0] prev,
			input logic [TIME_W-1:0] sample);
		return (sample > prev) ? sample : prev;
	endfunction

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign div_start = (state_q == ST_START) && (cycle_q != '0);

	// The finished result moves to the output register once it is free or emptying.
	assign hand_over = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// A strict compare at full width: the scaled limit is wider than the scan time.
	assign over_limit = (limit_us_q != '0) &&
		({{(LIMIT_US_W - TIME_W){1'b0}}, in_data.scan_time} > limit_us_q);

	// Any quotient bit above the load width means saturation.
	assign load_sat = (|quotient[DIVIDEND_W-1:LOAD_W]) ? LOAD_MAX : quotient[LOAD_W-1:0];

	stm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product_q),
		.divisor  (cycle_q),
		.quotient (quotient),
		.status   (div_status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_us_q <= '0;
		end else if (cfg_we) begin
			limit_us_q <= LIMIT_US_W'(cfg_wdata) * LIMIT_US_W'(MS_TO_US);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			product_q <= DIVIDEND_W'(in_data.work_time) * DIVIDEND_W'(LOAD_SCALE);
			cycle_q   <= in_data.cycle_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			first_seen_q <= 1'b0;
			avg_scan_q   <= '0;
			avg_work_q   <= '0;
			avg_cycle_q  <= '0;
			max_scan_q   <= '0;
			max_work_q   <= '0;
			max_cycle_q  <= '0;
			load_q       <= '0;
			overruns_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (hand_over) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						first_seen_q <= 1'b1;
						if (!first_seen_q) begin
							avg_scan_q  <= in_data.scan_time;
							avg_work_q  <= in_data.work_time;
							avg_cycle_q <= in_data.cycle_time;
						end else begin
							avg_scan_q  <= ema_eighth(avg_scan_q, in_data.scan_time);
							avg_work_q  <= ema_eighth(avg_work_q, in_data.work_time);
							avg_cycle_q <= ema_eighth(avg_cycle_q, in_data.cycle_time);
						end
						max_scan_q  <= peak_of(max_scan_q, in_data.scan_time);
						max_work_q  <= peak_of(max_work_q, in_data.work_time);
						max_cycle_q <= peak_of(max_cycle_q, in_data.cycle_time);
						if (over_limit) begin
							overruns_q <= overruns_q + COUNT_W'(1);
						end
						state_q <= ST_START;
					end
				end
				ST_START: begin
					// A zero cycle time leaves the load untouched and skips the divider.
					state_q <= (cycle_q != '0) ? ST_DIV : ST_FIN;
				end
				ST_DIV: begin
					if (div_status.done) begin
						load_q  <= load_sat;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (hand_over) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (hand_over) begin
			out_data_q.scan_average    <= avg_scan_q;
			out_data_q.scan_peak       <= max_scan_q;
			out_data_q.work_average    <= avg_work_q;
			out_data_q.work_peak       <= max_work_q;
			out_data_q.cycle_average   <= avg_cycle_q;
			out_data_q.cycle_peak      <= max_cycle_q;
			out_data_q.load_hundredths <= load_q;
			out_data_q.overrun_count   <= overruns_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
